// ----- hw/rtl/sts_pkg.sv -----
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the software timer scheduler
// Slot count, counter width, operation codes and the slot entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

   // sizing
   localparam int SLOTS       = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // item field widths
   localparam int OP_W     = 2;
   localparam int SLOT_W   = 4;
   localparam int PERIOD_W = 16;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_TICK       = 2'd0,
      OP_REGISTER   = 2'd1,
      OP_UNREGISTER = 2'd2,
      OP_NONE       = 2'd3
   } op_type;

   // one slot of the timer table
   typedef struct packed {
      logic                   armed;
      logic                   mode;
      logic [COUNT_WIDTH-1:0] period;
      logic [COUNT_WIDTH-1:0] remaining;
   } entry_type;

   // write command into the timer table
   typedef struct packed {
      logic      wr;
      entry_type data;
   } wr_cmd_type;

   // clamp a requested period to the counter range
   function automatic logic [COUNT_WIDTH-1:0] sat_period(input logic [PERIOD_W-1:0] p);
      logic [32:0] wide;
      wide = 33'(p);
      if (wide > 33'(COUNT_MAX)) begin
         return COUNT_MAX;
      end
      return wide[COUNT_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/software_timer_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// software_timer_scheduler_core: countdown timers multiplexed on one tick
// Register, unregister and tick items drive a table of slots; a tick
// reports every slot that expires, in ascending order.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                      | tuser | tlast
//  req_    | in  | slot[3:0] period[19:4] periodic[20] (24 b) | op    | -
//  rsp_    | out | expired_slot[3:0] (8 b)                    | -     | last
//
//  register and unregister complete in the idle state; a tick scans all SLOTS
//  slots through the shared decrement and compare unit, then steps through the
//  slots up to the highest expired one to hand out reports.
//  reset clears the armed and mode flags at once; no clearing pass.
//  a report waits in the output register; the emit phase stalls while it
//  is not taken, and req_tready stays low until the tick is finished.
// ----------------------------------------------------------------------------
`default_nettype none

module software_timer_scheduler_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // slot, period, periodic, zero pad
   input  wire logic [1:0]  req_tuser,   // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // expired_slot, zero pad
   output logic             rsp_tlast
);
   import sts_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [SLOTS-1:0]  exp_ff, exp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [SLOT_W-1:0]      in_slot;
   logic [PERIOD_W-1:0]    in_period;
   logic                   in_periodic;
   op_type                 in_op;
   logic                   accept;
   logic                   in_range;
   logic [IDX_W-1:0]       addr;
   wr_cmd_type             cmd;
   entry_type              entry;
   logic [COUNT_WIDTH-1:0] dec;
   logic                   hit;
   logic [SLOTS-1:0]       exp_rest;
   logic                   scan_end;
   logic                   out_free;

   // item fields
   assign in_slot     = req_tdata[SLOT_W-1:0];
   assign in_period   = req_tdata[SLOT_W+PERIOD_W-1:SLOT_W];
   assign in_periodic = req_tdata[SLOT_W+PERIOD_W];
   assign in_op       = op_type'(req_tuser);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign in_range   = (32'(in_slot) < SLOTS);
   assign addr       = (state_ff == ST_IDLE) ? IDX_W'(in_slot) : idx_ff;
   assign scan_end   = (32'(idx_ff) == SLOTS - 1);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   sts_slot_store u_store (
      .clock (clock),
      .reset (reset),
      .addr  (addr),
      .cmd   (cmd),
      .entry (entry)
   );

   // shared decrement and zero compare
   assign dec = (entry.remaining != '0) ? entry.remaining - 1'b1 : '0;
   assign hit = entry.armed && (dec == '0);

   // reports still pending once the current one is gone
   always_comb begin
      exp_rest         = exp_ff;
      exp_rest[idx_ff] = 1'b0;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      exp_in       = exp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;
      cmd          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (in_op)
                  OP_TICK: begin
                     state_in = ST_SCAN;
                     idx_in   = '0;
                     exp_in   = '0;
                  end
                  OP_REGISTER: begin
                     if (in_range && in_period != '0) begin
                        cmd.wr             = 1'b1;
                        cmd.data.armed     = 1'b1;
                        cmd.data.mode      = entry.armed ? entry.mode : in_periodic;
                        cmd.data.period    = sat_period(in_period);
                        cmd.data.remaining = sat_period(in_period);
                     end
                  end
                  OP_UNREGISTER: begin
                     if (in_range) begin
                        cmd.wr = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (entry.armed) begin
               cmd.wr   = 1'b1;
               cmd.data = entry;
               if (hit) begin
                  if (entry.mode) begin
                     cmd.data.remaining = entry.period;
                  end else begin
                     cmd.data = '0;
                  end
               end else begin
                  cmd.data.remaining = dec;
               end
            end
            exp_in[idx_ff] = hit;
            if (scan_end) begin
               state_in = ST_EMIT;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (exp_ff == '0) begin
               state_in = ST_IDLE;
            end else if (exp_ff[idx_ff]) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_slot_in  = SLOT_W'(idx_ff);
                  rsp_last_in  = (exp_rest == '0);
                  exp_in       = exp_rest;
                  idx_in       = idx_ff + 1'b1;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         exp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         exp_ff       <= exp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_slot_ff <= rsp_slot_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_slot_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/sts_slot_store.sv -----
// ----------------------------------------------------------------------------
// sts_slot_store: timer table
// Holds armed flag, mode, period and countdown of every slot; one shared
// address for read and write.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_slot_store (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [sts_pkg::IDX_W-1:0] addr,
   input  wire sts_pkg::wr_cmd_type      cmd,
   output sts_pkg::entry_type            entry
);
   import sts_pkg::*;

   logic [SLOTS-1:0]       armed_ff;
   logic [SLOTS-1:0]       mode_ff;
   logic [COUNT_WIDTH-1:0] period_ff [SLOTS];
   logic [COUNT_WIDTH-1:0] remaining_ff [SLOTS];

   // read side
   always_comb begin
      entry.armed     = armed_ff[addr];
      entry.mode      = mode_ff[addr];
      entry.period    = period_ff[addr];
      entry.remaining = remaining_ff[addr];
   end

   // flags, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
         mode_ff  <= '0;
      end else if (cmd.wr) begin
         armed_ff[addr] <= cmd.data.armed;
         mode_ff[addr]  <= cmd.data.mode;
      end
   end

   // counts, only read while the slot is armed
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         period_ff[addr]    <= cmd.data.period;
         remaining_ff[addr] <= cmd.data.remaining;
      end
   end

endmodule

`default_nettype wire
